### src/sexl_pkg.sv
package sexl_pkg;

    // Number accumulator width; the number_value field itself is fixed at 32 bits.
    localparam int VALUE_WIDTH   = 32;
    localparam int ACC_XW        = VALUE_WIDTH + 4;
    localparam int KW_SLOTS      = 6;
    localparam int KW_CHARS      = 8;
    localparam int KW_TEXT_W     = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int OUT_DATA_W    = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KW_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_TEXT0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_TEXT5 = 3'd6;

    // Token kinds as carried on tuser.
    typedef enum logic [2:0] {
        KIND_LPAREN  = 3'd0,
        KIND_RPAREN  = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_IDENT   = 3'd3,
        KIND_KEYWORD = 3'd4,
        KIND_STRING  = 3'd5,
        KIND_OTHER   = 3'd6,
        KIND_TEXT    = 3'd7
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text;
        logic [31:0] value;
        logic [2:0]  kw_idx;
        logic        ovf;
        logic        last;
    } t_result;

    // Character codes used by the lexer.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;

endpackage

### src/s_expression_lexer.sv
// Channel   Direction  tdata (low bit up)                                 tuser       tlast
// s_axis    in         char_code[7:0]                                     -           end_of_input
// m_axis    out        text_byte, number_value, keyword_index, overflow   token_kind  last_of_run
// cfg       in         write enable, register index, 64-bit data (no handshake)
//
// Each accepted byte is decoded in the cycle it is accepted, and its zero to three results
// are captured in a result bundle register. The bundle drains one result per cycle while
// m_axis is ready, so a byte that yields at most one result is taken every cycle; a byte
// with more results holds the input until the cycle in which the bundle's last result leaves.
// Reset is synchronous and active low; it empties the bundle and returns the lexer to idle.
// A stall on m_axis holds the current result and, through tready, the input.
module s_expression_lexer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,   // char_code
    input  logic                                   s_axis_tlast,   // end_of_input
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // text_byte[7:0], number_value[39:8], keyword_index[42:40], value_overflow[43], zero pad
    output logic [sexl_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic [2:0]                             m_axis_tuser,   // token_kind
    output logic                                   m_axis_tlast,   // last_of_run
    input  logic                                   i_cfg_we,
    input  logic [sexl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sexl_pkg::KW_TEXT_W-1:0]         i_cfg_data
);
    import sexl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_STRING,
        MODE_ESCAPE
    } t_mode;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_match;

    // Keyword table.
    logic [2:0]           r_kw_count;
    logic [KW_TEXT_W-1:0] r_kw [KW_SLOTS];

    // Lexer state.
    t_mode                  r_mode,   n_mode;
    logic [VALUE_WIDTH-1:0] r_acc,    n_acc;
    logic                   r_ovf,    n_ovf;
    logic [KW_TEXT_W-1:0]   r_prefix, n_prefix;
    logic [3:0]             r_len,    n_len;

    // Result bundle.
    t_result    r_res [3];
    t_result    n_res [3];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] r_idx;

    logic       s_xfer, m_xfer, last_pop;
    logic [7:0] c;

    assign c      = s_axis_tdata;
    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    // The bundle is finished once the result at the last position is transferred.
    assign last_pop      = m_xfer && (r_idx + 2'd1 == r_cnt);
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign s_axis_tready = (r_cnt == 2'd0) || last_pop;

    assign m_axis_tdata = {4'b0, r_res[r_idx].ovf, r_res[r_idx].kw_idx,
                           r_res[r_idx].value, r_res[r_idx].text};
    assign m_axis_tuser = r_res[r_idx].kind;
    assign m_axis_tlast = r_res[r_idx].last;

    function automatic t_result mk(input t_kind kind, input logic [7:0] text,
                                   input logic [31:0] value, input logic [2:0] kw_idx,
                                   input logic ovf);
        t_result r;
        r.kind   = kind;
        r.text   = text;
        r.value  = value;
        r.kw_idx = kw_idx;
        r.ovf    = ovf;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    endfunction

    // Lowest enabled keyword entry equal to the identifier, if it is short enough.
    function automatic t_match kw_match(input logic [KW_TEXT_W-1:0] prefix,
                                        input logic [3:0] len);
        t_match     m;
        logic [2:0] cnt;
        m.hit = 1'b0;
        m.idx = 3'd0;
        cnt   = (r_kw_count > 3'(KW_SLOTS)) ? 3'(KW_SLOTS) : r_kw_count;
        for (int k = KW_SLOTS - 1; k >= 0; k--) begin
            if (len <= 4'(KW_CHARS) && 3'(k) < cnt && r_kw[k] == prefix) begin
                m.hit = 1'b1;
                m.idx = 3'(k);
            end
        end
        return m;
    endfunction

    // Decode of one byte against the current state.
    always_comb begin
        logic                 start;
        logic                 is_digit;
        logic                 is_ident_ch;
        logic [7:0]           b;
        logic [ACC_XW-1:0]    prod;
        t_match               m;
        logic [1:0]           n;

        n_mode   = r_mode;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_prefix = r_prefix;
        n_len    = r_len;
        n        = 2'd0;
        start    = 1'b0;
        m        = '0;
        for (int i = 0; i < 3; i++) begin
            n_res[i] = mk(KIND_LPAREN, 8'd0, 32'd0, 3'd0, 1'b0);
        end

        is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
        is_ident_ch = is_letter(c) || (c == CH_UNDER) || (c == CH_DASH);
        b           = (c == CH_DASH) ? CH_UNDER : c;
        prod        = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                      + ACC_XW'(c - CH_ZERO);

        // Continue the open token, or close it and restart on this byte.
        unique case (r_mode)
            MODE_NUMBER: begin
                if (is_digit) begin
                    n_acc = prod[VALUE_WIDTH-1:0];
                    if (|prod[ACC_XW-1:VALUE_WIDTH]) begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    n_res[n] = mk(KIND_NUMBER, 8'd0, 32'(r_acc), 3'd0, r_ovf);
                    n        = n + 2'd1;
                    n_mode   = MODE_IDLE;
                    start    = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_ident_ch) begin
                    if (r_len < 4'(KW_CHARS)) begin
                        n_prefix = r_prefix | (KW_TEXT_W'(b) << {r_len[2:0], 3'b000});
                    end
                    if (r_len < 4'd15) begin
                        n_len = r_len + 4'd1;
                    end
                    n_res[n] = mk(KIND_TEXT, b, 32'd0, 3'd0, 1'b0);
                    n        = n + 2'd1;
                end else begin
                    m        = kw_match(r_prefix, r_len);
                    n_res[n] = mk(m.hit ? KIND_KEYWORD : KIND_IDENT, 8'd0, 32'd0,
                                  m.hit ? m.idx : 3'd0, 1'b0);
                    n        = n + 2'd1;
                    n_mode   = MODE_IDLE;
                    start    = 1'b1;
                end
            end
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    n_res[n] = mk(KIND_STRING, 8'd0, 32'd0, 3'd0, 1'b0);
                    n        = n + 2'd1;
                    n_mode   = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    n_res[n] = mk(KIND_TEXT, c, 32'd0, 3'd0, 1'b0);
                    n        = n + 2'd1;
                end
            end
            MODE_ESCAPE: begin
                n_res[n] = mk(KIND_TEXT, (c == CH_LC_N) ? CH_LF :
                                         (c == CH_LC_T) ? CH_TAB : c,
                              32'd0, 3'd0, 1'b0);
                n        = n + 2'd1;
                n_mode   = MODE_STRING;
            end
            default: begin
                n_mode = MODE_IDLE;
                start  = 1'b1;
            end
        endcase

        // Start of a new token from the idle state.
        if (start) begin
            priority if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
                n = n;
            end else if (c == CH_LPAREN) begin
                n_res[n] = mk(KIND_LPAREN, 8'd0, 32'd0, 3'd0, 1'b0);
                n        = n + 2'd1;
            end else if (c == CH_RPAREN) begin
                n_res[n] = mk(KIND_RPAREN, 8'd0, 32'd0, 3'd0, 1'b0);
                n        = n + 2'd1;
            end else if (c == CH_QUOTE) begin
                n_mode = MODE_STRING;
            end else if (is_digit) begin
                n_mode = MODE_NUMBER;
                n_acc  = VALUE_WIDTH'(c - CH_ZERO);
                n_ovf  = 1'b0;
            end else if (is_letter(c) || c == CH_UNDER) begin
                n_mode   = MODE_IDENT;
                n_prefix = KW_TEXT_W'(c);
                n_len    = 4'd1;
                n_res[n] = mk(KIND_TEXT, c, 32'd0, 3'd0, 1'b0);
                n        = n + 2'd1;
            end else begin
                n_res[n] = mk(KIND_OTHER, c, 32'd0, 3'd0, 1'b0);
                n        = n + 2'd1;
            end
        end

        // End of input closes whatever token is still open.
        if (s_axis_tlast) begin
            unique case (n_mode)
                MODE_NUMBER: begin
                    n_res[n] = mk(KIND_NUMBER, 8'd0, 32'(n_acc), 3'd0, n_ovf);
                    n        = n + 2'd1;
                end
                MODE_IDENT: begin
                    m        = kw_match(n_prefix, n_len);
                    n_res[n] = mk(m.hit ? KIND_KEYWORD : KIND_IDENT, 8'd0, 32'd0,
                                  m.hit ? m.idx : 3'd0, 1'b0);
                    n        = n + 2'd1;
                end
                MODE_STRING, MODE_ESCAPE: begin
                    n_res[n] = mk(KIND_STRING, 8'd0, 32'd0, 3'd0, 1'b0);
                    n        = n + 2'd1;
                end
                default: begin
                    n = n;
                end
            endcase
            n_mode = MODE_IDLE;
        end

        // Mark the final result of this byte.
        if (n != 2'd0) begin
            n_res[n - 2'd1].last = 1'b1;
        end
        n_cnt = n;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_count <= 3'd0;
            for (int k = 0; k < KW_SLOTS; k++) begin
                r_kw[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_KW_COUNT) begin
                r_kw_count <= i_cfg_data[2:0];
            end
            for (int k = 0; k < KW_SLOTS; k++) begin
                if (i_cfg_index == CFG_KW_TEXT0 + 3'(k) && i_cfg_index <= CFG_KW_TEXT5) begin
                    r_kw[k] <= i_cfg_data;
                end
            end
        end
    end

    // Lexer state and result bundle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_prefix <= '0;
            r_len    <= 4'd0;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            if (s_xfer) begin
                r_mode   <= n_mode;
                r_acc    <= n_acc;
                r_ovf    <= n_ovf;
                r_prefix <= n_prefix;
                r_len    <= n_len;
                r_cnt    <= n_cnt;
                r_idx    <= 2'd0;
            end else if (last_pop) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else if (m_xfer) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= n_res[i];
            end
        end
    end

endmodule

### src/sexl_checker.sv
module sexl_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [sexl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic [2:0]                          m_axis_tuser,
    input logic                                m_axis_tlast
);
    import sexl_pkg::*;

    // A stalled result holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The output is empty right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Only text and other tokens carry a byte.
    a_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_TEXT && m_axis_tuser != KIND_OTHER
            |-> m_axis_tdata[7:0] == 8'd0)
        else $error("byte on a token without text");

    // Value and overflow belong to number tokens only.
    a_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_NUMBER
            |-> m_axis_tdata[39:8] == 32'd0 && !m_axis_tdata[43])
        else $error("number fields on a non-number token");

    // A keyword index names a table entry and appears only on keyword tokens.
    a_keyword: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[42:40] < 3'(KW_SLOTS)
            && (m_axis_tuser == KIND_KEYWORD || m_axis_tdata[42:40] == 3'd0))
        else $error("bad keyword index");

endmodule

bind s_expression_lexer sexl_checker u_sexl_checker (.*);
